// File: hw/rtl/rida_pkg.sv
// Shared types, constants and helpers for the range ID allocator.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package rida_pkg;

    // Pool geometry. POOL_DEPTH is a power of two.
    localparam int POOL_DEPTH = 1024;
    localparam int ID_WIDTH   = 16;
    localparam int PTR_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int FRESH_W    = ID_WIDTH + 1;

    typedef logic [ID_WIDTH-1:0] t_id;
    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [FRESH_W-1:0]  t_fresh;

    // Command codes.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    // Configuration register indexes.
    localparam logic REG_MIN_ID = 1'b0;
    localparam logic REG_MAX_ID = 1'b1;

    localparam t_id RST_MIN_ID = ID_WIDTH'(3000);
    localparam t_id RST_MAX_ID = ID_WIDTH'(3999);

    // Write request into the free-list RAM.
    typedef struct packed {
        logic en;
        t_ptr addr;
        t_id  data;
    } t_q_wr;

    // Write request into the membership bitmap.
    typedef struct packed {
        logic en;
        t_ptr addr;
        logic data;
    } t_bm_wr;

    // Read request, shared by both memories.
    typedef struct packed {
        logic en;
        t_ptr addr;
    } t_rd;

    // Bitmap slot of an identifier: its offset from min_id, folded onto the pool.
    function automatic t_ptr bit_index(t_id id, t_id min_id);
        t_id diff;
        diff = id - min_id;
        return PTR_W'(diff % POOL_DEPTH);
    endfunction

endpackage

// File: hw/rtl/rida_queue_ram.sv
// Free-list storage: a single-write, single-read RAM with a registered read port.
// Depends on rida_pkg for widths and the request structs.

module rida_queue_ram (
    input  logic            i_clk,
    input  rida_pkg::t_q_wr i_wr,
    input  rida_pkg::t_rd   i_rd,
    output rida_pkg::t_id   o_rd_data
);

    rida_pkg::t_id mem [rida_pkg::POOL_DEPTH];
    rida_pkg::t_id r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // A read that hits the entry being written in the same cycle returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            if (i_wr.en && (i_wr.addr == i_rd.addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= mem[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/rida_bitmap.sv
// Membership bitmap of the free list, with a clearing sweep after reset and on request.
// Depends on rida_pkg for widths and the request structs.

module rida_bitmap (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear_start,
    input  rida_pkg::t_bm_wr i_wr,
    input  rida_pkg::t_rd    i_rd,
    output logic             o_rd_bit,
    output logic             o_clearing
);

    logic          mem [rida_pkg::POOL_DEPTH];
    logic          r_rd_bit;
    logic          r_clearing;
    rida_pkg::t_ptr r_clr_addr;
    logic          n_clearing;
    rida_pkg::t_ptr n_clr_addr;
    logic          wr_en;
    rida_pkg::t_ptr wr_addr;
    logic          wr_data;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == rida_pkg::PTR_W'(rida_pkg::POOL_DEPTH - 1)) begin
                n_clearing = 1'b0;
            end
        end else if (i_clear_start) begin
            n_clearing = 1'b1;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // The sweep owns the write port while it runs; no command is in flight then.
    assign wr_en   = r_clearing | i_wr.en;
    assign wr_addr = r_clearing ? r_clr_addr : i_wr.addr;
    assign wr_data = r_clearing ? 1'b0 : i_wr.data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            if (i_wr.en && (i_wr.addr == i_rd.addr)) begin
                r_rd_bit <= i_wr.data;
            end else begin
                r_rd_bit <= mem[i_rd.addr];
            end
        end
    end

    assign o_rd_bit   = r_rd_bit;
    assign o_clearing = r_clearing;

endmodule

// File: hw/rtl/rida_ctrl.sv
// Command decode, allocator state, configuration registers and result register.
// Depends on rida_pkg; drives the free-list RAM and the membership bitmap.

module rida_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_command,
    input  rida_pkg::t_id    i_free_id,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  rida_pkg::t_id    i_cfg_data,
    input  rida_pkg::t_id    i_q_rd_data,
    input  logic             i_bm_rd_bit,
    input  logic             i_bm_clearing,
    output rida_pkg::t_rd    o_q_rd,
    output rida_pkg::t_q_wr  o_q_wr,
    output rida_pkg::t_rd    o_bm_rd,
    output rida_pkg::t_bm_wr o_bm_wr,
    output logic             o_bm_clear_start,
    output logic             o_done,
    output rida_pkg::t_id    o_granted_id,
    output logic [1:0]       o_status
);

    logic accept;

    // Configuration.
    rida_pkg::t_id r_min_id;
    rida_pkg::t_id r_max_id;

    // Allocator state.
    rida_pkg::t_fresh r_next_fresh;
    rida_pkg::t_ptr   r_head;
    rida_pkg::t_ptr   r_tail;
    rida_pkg::t_cnt   r_count;
    rida_pkg::t_fresh n_next_fresh;
    rida_pkg::t_ptr   n_head;
    rida_pkg::t_ptr   n_tail;
    rida_pkg::t_cnt   n_count;

    // Input register.
    logic          r_valid;
    logic [1:0]    r_cmd;
    rida_pkg::t_id r_id;

    // Result register.
    logic          r_done;
    rida_pkg::t_id r_granted;
    logic [1:0]    r_status;
    rida_pkg::t_id n_granted;
    logic [1:0]    n_status;

    // A clear in the input register blocks acceptance until its sweep has finished.
    assign busy   = i_bm_clearing | (r_valid & (r_cmd == rida_pkg::CMD_CLEAR));
    assign accept = start & ~busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_id <= rida_pkg::RST_MIN_ID;
            r_max_id <= rida_pkg::RST_MAX_ID;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rida_pkg::REG_MIN_ID: r_min_id <= i_cfg_data;
                rida_pkg::REG_MAX_ID: r_max_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_next_fresh     = r_next_fresh;
        n_head           = r_head;
        n_tail           = r_tail;
        n_count          = r_count;
        n_granted        = '0;
        n_status         = rida_pkg::ST_OK;
        o_q_wr           = '0;
        o_bm_wr          = '0;
        o_bm_clear_start = 1'b0;
        if (r_valid) begin
            case (r_cmd)
                rida_pkg::CMD_ALLOC: begin
                    if (r_count != '0) begin
                        n_granted    = i_q_rd_data;
                        o_bm_wr.en   = 1'b1;
                        o_bm_wr.addr = rida_pkg::bit_index(i_q_rd_data, r_min_id);
                        o_bm_wr.data = 1'b0;
                        n_head       = (r_head == rida_pkg::PTR_W'(rida_pkg::POOL_DEPTH - 1)) ?
                                       '0 : r_head + 1'b1;
                        n_count      = r_count - 1'b1;
                    end else if (r_next_fresh > {1'b0, r_max_id}) begin
                        n_status = rida_pkg::ST_EXHAUSTED;
                    end else begin
                        n_granted    = r_next_fresh[rida_pkg::ID_WIDTH-1:0];
                        n_next_fresh = r_next_fresh + 1'b1;
                    end
                end
                rida_pkg::CMD_FREE: begin
                    if ((r_id < r_min_id) || (r_id > r_max_id) ||
                        ({1'b0, r_id} >= r_next_fresh)) begin
                        n_status = rida_pkg::ST_REJECTED;
                    end else if (i_bm_rd_bit ||
                                 (r_count >= rida_pkg::CNT_W'(rida_pkg::POOL_DEPTH))) begin
                        n_status = rida_pkg::ST_DUPLICATE;
                    end else begin
                        o_q_wr.en    = 1'b1;
                        o_q_wr.addr  = r_tail;
                        o_q_wr.data  = r_id;
                        o_bm_wr.en   = 1'b1;
                        o_bm_wr.addr = rida_pkg::bit_index(r_id, r_min_id);
                        o_bm_wr.data = 1'b1;
                        n_tail       = (r_tail == rida_pkg::PTR_W'(rida_pkg::POOL_DEPTH - 1)) ?
                                       '0 : r_tail + 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                end
                rida_pkg::CMD_CLEAR: begin
                    n_next_fresh     = {1'b0, r_min_id};
                    n_head           = '0;
                    n_tail           = '0;
                    n_count          = '0;
                    o_bm_clear_start = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Reads for the incoming command go out at the accepting edge. The head address
    // already reflects the command finishing at that same edge.
    always_comb begin
        o_q_rd.en    = accept;
        o_q_rd.addr  = n_head;
        o_bm_rd.en   = accept;
        o_bm_rd.addr = rida_pkg::bit_index(i_free_id, r_min_id);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_fresh <= {1'b0, rida_pkg::RST_MIN_ID};
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_valid      <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_next_fresh <= n_next_fresh;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_valid      <= accept;
            r_done       <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_id  <= i_free_id;
        end
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_done       = r_done;
    assign o_granted_id = r_granted;
    assign o_status     = r_status;

endmodule

// File: hw/rtl/range_id_allocator_top.sv
// Top level of the range ID allocator: joins control, free-list RAM and bitmap.
// Depends on rida_pkg, rida_ctrl, rida_queue_ram and rida_bitmap.
// A transferred command passes through the input register and then the result register;
// its result is on the outputs for the one cycle marked by o_done. One command per cycle
// is taken while busy is low, set by the registered reads of the free-list RAM and the
// bitmap. A clear holds busy high while the bitmap is swept. Reset is synchronous, active
// low; after it, busy stays high during the sweep. The receiver cannot stall results.

module range_id_allocator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Command channel: a transfer happens when start is high and busy is low.
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_command,
    input  rida_pkg::t_id i_free_id,
    // Configuration write channel.
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  rida_pkg::t_id i_cfg_data,
    // Result, valid for exactly the one cycle in which o_done is high.
    output logic          o_done,
    output rida_pkg::t_id o_granted_id,
    output logic [1:0]    o_status
);

    rida_pkg::t_rd    q_rd;
    rida_pkg::t_q_wr  q_wr;
    rida_pkg::t_id    q_rd_data;
    rida_pkg::t_rd    bm_rd;
    rida_pkg::t_bm_wr bm_wr;
    logic             bm_rd_bit;
    logic             bm_clearing;
    logic             bm_clear_start;

    // The control block holds the configuration, the counter of fresh identifiers and
    // the free-list pointers. Each command sits in its input register, where the memory
    // read data arrives, and is decided there in a single pass.
    rida_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_free_id        (i_free_id),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_q_rd_data      (q_rd_data),
        .i_bm_rd_bit      (bm_rd_bit),
        .i_bm_clearing    (bm_clearing),
        .o_q_rd           (q_rd),
        .o_q_wr           (q_wr),
        .o_bm_rd          (bm_rd),
        .o_bm_wr          (bm_wr),
        .o_bm_clear_start (bm_clear_start),
        .o_done           (o_done),
        .o_granted_id     (o_granted_id),
        .o_status         (o_status)
    );

    // The free list is a circular FIFO in RAM. Its head entry is read as a command is
    // transferred; a push landing on that entry in the same cycle is forwarded.
    rida_queue_ram u_queue (
        .i_clk     (i_clk),
        .i_wr      (q_wr),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data)
    );

    // The bitmap flags identifiers waiting in the free list, so a duplicate free is
    // caught without scanning. It is swept to zero after reset and after every clear.
    rida_bitmap u_bitmap (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear_start (bm_clear_start),
        .i_wr          (bm_wr),
        .i_rd          (bm_rd),
        .o_rd_bit      (bm_rd_bit),
        .o_clearing    (bm_clearing)
    );

endmodule

// File: hw/rtl/rida_checker.sv
// Port-level checks on the range ID allocator, attached by bind to the top level.
// Depends on rida_pkg and range_id_allocator_top.

module rida_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic [1:0]    i_command,
    input logic          o_done,
    input rida_pkg::t_id o_granted_id,
    input logic [1:0]    o_status
);

    // Every transfer yields exactly one result, after the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("missing result after a command transfer");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without a command transfer");

    // A result with an error status never hands out a nonzero identifier.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != rida_pkg::ST_OK)) |-> (o_granted_id == '0))
        else $error("identifier granted with an error status");

    // A clear answers with zero and ok, and blocks commands while the bitmap is swept.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == rida_pkg::CMD_CLEAR)) |=>
            busy ##1 (o_done && (o_status == rida_pkg::ST_OK) && (o_granted_id == '0)))
        else $error("clear handled incorrectly");

endmodule

bind range_id_allocator_top rida_checker u_rida_checker (.*);
